### rtl/lrt_pkg.sv
package lrt_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam int ADDR_W = 32;
  localparam int LEN_W = 6;
  localparam int PORT_W = 8;
  localparam int MET_W = 5;
  localparam int KIND_W = 2;
  localparam logic [LEN_W-1:0] MAX_PREFIX = 6'd32;
  localparam logic [MET_W-1:0] METRIC_UNREACHABLE = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_length;
    logic [PORT_W-1:0] out_port;
    logic [ADDR_W-1:0] next_hop;
    logic [MET_W-1:0]  metric;
  } op_t;

  typedef struct packed {
    logic              hit;
    logic              table_full;
    logic [ADDR_W-1:0] result_next_hop;
    logic [PORT_W-1:0] result_port;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_APPLY,
    ST_OUT
  } st_t;

  function automatic logic [ADDR_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len >= MAX_PREFIX) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} << len[4:0]);
    end
    return m;
  endfunction

endpackage

### rtl/lrt_if.sv
interface lrt_op_if;
  logic          valid;
  logic          ready;
  lrt_pkg::op_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lrt_res_if;
  logic          valid;
  logic          ready;
  lrt_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/lrt_front.sv
// Two-entry queue in front of the table engine.
module lrt_front (
  input  logic         clk,
  input  logic         rst,
  lrt_op_if.sink       in_ch,
  output logic         q_valid,
  output lrt_pkg::op_t q_op,
  input  logic         q_pop
);
  lrt_pkg::op_t buf_q [2];
  logic         rd_ptr;
  logic         wr_ptr;
  logic [1:0]   count;
  logic         push;

  // No word is taken while reset is held.
  assign in_ch.ready = !rst && (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign q_op = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule

### rtl/lrt_engine.sv
// Scans every slot once per operation, then applies the update and
// presents the result from a register.
module lrt_engine #(
  parameter int ENTRIES = lrt_pkg::ENTRIES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  lrt_pkg::op_t q_op,
  output logic         q_pop,
  lrt_res_if.source    out_ch
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef struct packed {
    logic [lrt_pkg::ADDR_W-1:0] prefix;
    logic [lrt_pkg::LEN_W-1:0]  len;
    logic [lrt_pkg::ADDR_W-1:0] hop;
    logic [lrt_pkg::PORT_W-1:0] port;
    logic [lrt_pkg::MET_W-1:0]  metric;
  } slot_t;

  slot_t        mem [ENTRIES];
  logic [ENTRIES-1:0] valid_bits;

  lrt_pkg::st_t state, state_next;
  lrt_pkg::op_t op;
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_idx;
  slot_t        rd_data;
  logic         rd_ok;
  logic [IW-1:0] rd_at;

  logic         pair_found;
  logic [IW-1:0] pair_idx;
  logic         free_found;
  logic [IW-1:0] free_idx;
  logic         best_found;
  logic [lrt_pkg::LEN_W-1:0] best_len;
  logic [lrt_pkg::ADDR_W-1:0] best_hop;
  logic [lrt_pkg::PORT_W-1:0] best_port;
  logic [lrt_pkg::MET_W-1:0]  pair_metric;
  logic [lrt_pkg::ADDR_W-1:0] pair_hop;

  lrt_pkg::res_t res;
  lrt_pkg::res_t res_next;
  logic         len_ok;
  logic         is_pair;
  logic         usable;
  logic         wr_en;
  logic [IW-1:0] wr_idx;
  slot_t        wr_data;

  assign len_ok = (op.prefix_length <= lrt_pkg::MAX_PREFIX);
  assign rd_idx = idx;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    rd_at   <= rd_idx;
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= (state == lrt_pkg::ST_SCAN);
    end
  end

  assign is_pair = valid_bits[rd_at] && rd_data.prefix == op.address
                   && rd_data.len == op.prefix_length;
  assign usable = valid_bits[rd_at]
                  && rd_data.prefix == (op.address & lrt_pkg::low_mask(rd_data.len))
                  && rd_data.metric >= 5'd1
                  && rd_data.metric < lrt_pkg::METRIC_UNREACHABLE
                  && (rd_data.hop != '0 || rd_data.port != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      lrt_pkg::ST_IDLE: if (q_valid) state_next = lrt_pkg::ST_SCAN;
      lrt_pkg::ST_SCAN: if (idx == IW'(ENTRIES - 1)) state_next = lrt_pkg::ST_LAST;
      lrt_pkg::ST_LAST: state_next = lrt_pkg::ST_APPLY;
      lrt_pkg::ST_APPLY: state_next = lrt_pkg::ST_OUT;
      lrt_pkg::ST_OUT: if (out_ch.ready) state_next = lrt_pkg::ST_IDLE;
      default: state_next = lrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == lrt_pkg::ST_IDLE) && q_valid;
    out_ch.valid = (state == lrt_pkg::ST_OUT);
    out_ch.payload = res;
    wr_en = 1'b0;
    wr_idx = free_idx;
    wr_data.prefix = op.address;
    wr_data.len = op.prefix_length;
    wr_data.hop = op.next_hop;
    wr_data.port = op.out_port;
    wr_data.metric = op.metric;
    if (state == lrt_pkg::ST_APPLY && op.kind == lrt_pkg::KIND_INSERT && len_ok) begin
      if (pair_found) begin
        wr_idx = pair_idx;
        wr_en = (op.metric < pair_metric) || (op.next_hop == pair_hop);
      end else begin
        wr_en = free_found;
      end
    end
  end

  // Result word assembled from the scan summary.
  always_comb begin
    res_next = '0;
    if (op.kind == lrt_pkg::KIND_QUERY && best_found) begin
      res_next.hit = 1'b1;
      res_next.result_next_hop = best_hop;
      res_next.result_port = best_port;
    end
    if (op.kind == lrt_pkg::KIND_INSERT && len_ok && !pair_found && !free_found) begin
      res_next.table_full = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrt_pkg::ST_IDLE;
      valid_bits <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        valid_bits[wr_idx] <= 1'b1;
      end
      if (state == lrt_pkg::ST_APPLY && op.kind == lrt_pkg::KIND_DELETE && len_ok
          && pair_found) begin
        valid_bits[pair_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lrt_pkg::ST_IDLE) begin
      op <= q_op;
      idx <= '0;
      pair_found <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      best_len <= '0;
    end
    if (state == lrt_pkg::ST_SCAN && idx != IW'(ENTRIES - 1)) begin
      idx <= idx + 1'b1;
    end
    if (rd_ok) begin
      if (is_pair && !pair_found) begin
        pair_found <= 1'b1;
        pair_idx <= rd_at;
        pair_metric <= rd_data.metric;
        pair_hop <= rd_data.hop;
      end
      if (!valid_bits[rd_at] && !free_found) begin
        free_found <= 1'b1;
        free_idx <= rd_at;
      end
      if (usable && (!best_found || rd_data.len > best_len)) begin
        best_found <= 1'b1;
        best_len <= rd_data.len;
        best_hop <= rd_data.hop;
        best_port <= rd_data.port;
      end
    end
    if (state == lrt_pkg::ST_APPLY) begin
      res <= res_next;
    end
  end
endmodule

### rtl/lpm_route_table_unit.sv
// Operations are handled one at a time: the engine sweeps the slot memory
// through its single read port, once per operation, while the queue holds
// further words; a stalled result holds the engine until it is taken.
// Reset: rst, synchronous and active high, clears every slot's valid bit,
// the input queue and the engine state; the block accepts words at once.
module lpm_route_table_unit #(
  parameter int ENTRIES = lrt_pkg::ENTRIES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  lrt_op_if.sink    in_ch,
  lrt_res_if.source out_ch
);
  // The queue lets an operation wait while the engine finishes the last one.
  logic         q_valid;
  logic         q_pop;
  lrt_pkg::op_t q_op;

  lrt_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop)
  );

  // The engine sweeps the table, keeps the matching pair, the first free
  // slot and the longest usable prefix, then writes back and reports.
  lrt_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_op(q_op),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

### rtl/lrt_checker.sv
module lrt_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input lrt_pkg::res_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_payload.hit && out_payload.table_full))
    else $error("hit and full together");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.hit |-> out_payload.result_next_hop == '0
    && out_payload.result_port == '0)
    else $error("miss with data");
  a_hit_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.hit |-> out_payload.result_next_hop != '0
    || out_payload.result_port != '0)
    else $error("hit without route");
endmodule

bind lpm_route_table_unit lrt_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
